@@ sv/timer_pool_service_defines.svh @@
// Assertion macros used by the timer pool port checker
`ifndef TIMER_POOL_SERVICE_DEFINES_SVH
`define TIMER_POOL_SERVICE_DEFINES_SVH

// check that the consequent holds in the same cycle as the antecedent
`define TPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// check that the consequent holds in the cycle after the antecedent
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tps_pkg.sv @@
// Types and codes for the timer pool service
package tps_pkg;

    localparam logic [1:0] OP_SET     = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_SERVICE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  task_id;
        logic [7:0]  signal;
        logic [30:0] duration;
        logic        periodic;
        logic [15:0] tick_amount;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  expired_task;
        logic [7:0]  expired_signal;
        logic [4:0]  slots_used;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [7:0]  signal;
        logic [30:0] counter;
        logic [30:0] period;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_SVC,
        S_EMIT,
        S_ACK
    } t_state;

endpackage

@@ sv/tps_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module tps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/tps_core.sv @@
// Slot scan sequencer and read-modify-write datapath of the timer pool
module tps_core #(
    parameter int POOL_SIZE = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tps_pkg::t_cmd    i_cmd,
    output logic             o_busy,
    output logic             o_res_valid,
    output tps_pkg::t_result o_res
);

    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam int EW = $bits(tps_pkg::t_entry);
    localparam logic [IW:0] N_CNT = (IW + 1)'(POOL_SIZE);

    tps_pkg::t_state      r_state, n_state;
    logic [IW:0]          r_cnt, n_cnt;
    logic                 r_pv, n_pv;
    logic [IW-1:0]        r_pidx, n_pidx;
    logic [POOL_SIZE-1:0] r_enabled, n_enabled;
    logic [POOL_SIZE-1:0] r_exp, n_exp;
    logic [CW-1:0]        r_used, n_used;
    logic [31:0]          r_acc, n_acc;
    logic [31:0]          r_spent, n_spent;
    tps_pkg::t_cmd        r_cmd, n_cmd;
    logic                 r_hit, n_hit;
    logic [IW-1:0]        r_hit_idx, n_hit_idx;
    logic [30:0]          r_hit_period, n_hit_period;
    logic                 r_free, n_free;
    logic [IW-1:0]        r_free_idx, n_free_idx;
    logic [1:0]           r_status, n_status;

    logic                 we;
    logic [IW-1:0]        wr_addr;
    tps_pkg::t_entry      wr_ent;
    logic [EW-1:0]        rd_data;
    tps_pkg::t_entry      ent;
    logic                 issue;
    logic                 done;
    logic                 en;
    logic [32:0]          diff;
    logic [8:0]           used_w;

    tps_ram #(
        .WIDTH (EW),
        .DEPTH (POOL_SIZE)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (EW'(wr_ent)),
        .i_rd_addr (r_cnt[IW-1:0]),
        .o_rd_data (rd_data)
    );

    assign ent    = tps_pkg::t_entry'(rd_data);
    assign issue  = (r_cnt != N_CNT);
    assign done   = !issue && !r_pv;
    assign en     = r_enabled[r_pidx];
    assign diff   = {2'b00, ent.counter} - {1'b0, r_spent};
    assign used_w = 9'(r_used);
    assign o_busy = (r_state != tps_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tps_pkg::S_IDLE;
            r_cnt     <= '0;
            r_pv      <= 1'b0;
            r_enabled <= '0;
            r_exp     <= '0;
            r_used    <= '0;
            r_acc     <= '0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_status  <= tps_pkg::ST_OK;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_pv      <= n_pv;
            r_enabled <= n_enabled;
            r_exp     <= n_exp;
            r_used    <= n_used;
            r_acc     <= n_acc;
            r_hit     <= n_hit;
            r_free    <= n_free;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx       <= n_pidx;
        r_spent      <= n_spent;
        r_cmd        <= n_cmd;
        r_hit_idx    <= n_hit_idx;
        r_hit_period <= n_hit_period;
        r_free_idx   <= n_free_idx;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pv         = r_pv;
        n_pidx       = r_pidx;
        n_enabled    = r_enabled;
        n_exp        = r_exp;
        n_used       = r_used;
        n_acc        = r_acc;
        n_spent      = r_spent;
        n_cmd        = r_cmd;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_period = r_hit_period;
        n_free       = r_free;
        n_free_idx   = r_free_idx;
        n_status     = r_status;
        we           = 1'b0;
        wr_addr      = r_pidx;
        wr_ent       = ent;
        o_res_valid  = 1'b0;
        o_res        = '0;

        // advance the slot pointer in every scanning pass
        if (r_state == tps_pkg::S_SCAN || r_state == tps_pkg::S_SVC ||
            r_state == tps_pkg::S_EMIT) begin
            n_pv   = issue;
            n_pidx = r_cnt[IW-1:0];
            if (issue) begin
                n_cnt = r_cnt + 1'b1;
            end
        end

        unique case (r_state)
            tps_pkg::S_IDLE: begin
                if (i_start) begin
                    n_cmd    = i_cmd;
                    n_status = tps_pkg::ST_OK;
                    n_cnt    = '0;
                    n_pv     = 1'b0;
                    n_hit    = 1'b0;
                    n_free   = 1'b0;
                    unique case (i_cmd.operation) inside
                        tps_pkg::OP_SET, tps_pkg::OP_REMOVE: begin
                            n_state = tps_pkg::S_SCAN;
                        end
                        tps_pkg::OP_TICK: begin
                            n_acc   = r_acc + 32'(i_cmd.tick_amount);
                            n_state = tps_pkg::S_ACK;
                        end
                        default: begin
                            n_spent = r_acc;
                            n_acc   = '0;
                            n_exp   = '0;
                            n_state = tps_pkg::S_SVC;
                        end
                    endcase
                end
            end
            tps_pkg::S_SCAN: begin
                if (r_pv) begin
                    if (en && !r_hit && ent.task_id == r_cmd.task_id &&
                        ent.signal == r_cmd.signal) begin
                        n_hit        = 1'b1;
                        n_hit_idx    = r_pidx;
                        n_hit_period = ent.period;
                    end
                    if (!en && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_pidx;
                    end
                end
                if (done) begin
                    n_state = tps_pkg::S_COMMIT;
                end
            end
            tps_pkg::S_COMMIT: begin
                wr_ent.task_id = r_cmd.task_id;
                wr_ent.signal  = r_cmd.signal;
                wr_ent.counter = r_cmd.duration;
                wr_ent.period  = r_hit_period;
                if (r_cmd.operation == tps_pkg::OP_SET) begin
                    if (r_hit) begin
                        we      = 1'b1;
                        wr_addr = r_hit_idx;
                    end else if (r_free) begin
                        we            = 1'b1;
                        wr_addr       = r_free_idx;
                        wr_ent.period = r_cmd.periodic ? r_cmd.duration : '0;
                        n_enabled[r_free_idx] = 1'b1;
                        n_used        = r_used + 1'b1;
                    end else begin
                        n_status = tps_pkg::ST_FULL;
                    end
                end else begin
                    if (r_hit) begin
                        n_enabled[r_hit_idx] = 1'b0;
                        if (r_used != '0) begin
                            n_used = r_used - 1'b1;
                        end
                    end else begin
                        n_status = tps_pkg::ST_NOT_FOUND;
                    end
                end
                n_state = tps_pkg::S_ACK;
            end
            tps_pkg::S_SVC: begin
                if (r_pv && en) begin
                    we = 1'b1;
                    if (diff[32] || diff == '0) begin
                        n_exp[r_pidx] = 1'b1;
                        if (ent.period == '0) begin
                            we                = 1'b0;
                            n_enabled[r_pidx] = 1'b0;
                            if (r_used != '0) begin
                                n_used = r_used - 1'b1;
                            end
                        end else begin
                            wr_ent.counter = ent.period;
                        end
                    end else begin
                        wr_ent.counter = diff[30:0];
                    end
                end
                if (done) begin
                    n_cnt   = '0;
                    n_state = tps_pkg::S_EMIT;
                end
            end
            tps_pkg::S_EMIT: begin
                if (r_pv && r_exp[r_pidx]) begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = tps_pkg::KIND_EXPIRY;
                    o_res.status         = tps_pkg::ST_OK;
                    o_res.expired_task   = ent.task_id;
                    o_res.expired_signal = ent.signal;
                    o_res.slots_used     = used_w[4:0];
                    o_res.last           = 1'b0;
                end
                if (done) begin
                    n_state = tps_pkg::S_ACK;
                end
            end
            tps_pkg::S_ACK: begin
                o_res_valid      = 1'b1;
                o_res.kind       = tps_pkg::KIND_ACK;
                o_res.status     = r_status;
                o_res.slots_used = used_w[4:0];
                o_res.last       = 1'b1;
                n_state          = tps_pkg::S_IDLE;
            end
            default: begin
                n_state = tps_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/timer_pool_service.sv @@
// Timer pool service top level: slot sequencer and registered result word
// A set or remove scans every slot before its ack word shows; add ticks needs no scan.
// Service: a slot pass, then an expiry pass with the expiry words, then the ack word;
// the next start is taken while the ack word shows. Synchronous active-low reset
// frees every slot and clears the tick and used counts; the slot RAM keeps its
// contents and needs no clearing pass.
module timer_pool_service #(
    parameter int POOL_SIZE = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tps_pkg::t_cmd    i_cmd,
    output logic             o_strobe,
    output tps_pkg::t_result o_result
);

    logic             res_valid;
    tps_pkg::t_result res;
    logic             r_strobe;
    tps_pkg::t_result r_result;

    tps_core #(
        .POOL_SIZE (POOL_SIZE)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_result <= res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ sv/tps_checker.sv @@
// Port-level checks of the timer pool service and their binding
`include "timer_pool_service_defines.svh"

module tps_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_strobe,
    input tps_pkg::t_result o_result
);

    `TPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `TPS_ASSERT_SAME(a_last_is_ack, o_strobe, o_result.last == !o_result.kind, "last and kind disagree")
    `TPS_ASSERT_SAME(a_expiry_ok, o_strobe && o_result.kind, o_result.status == tps_pkg::ST_OK, "expiry word with bad status")
    `TPS_ASSERT_SAME(a_ack_frees, o_strobe && o_result.last, !busy, "still busy after ack word")
    `TPS_ASSERT_SAME(a_expiry_busy, o_strobe && !o_result.last, busy, "expiry word shown while idle")

endmodule

bind timer_pool_service tps_checker u_tps_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

@@ sim/timer_pool_service_checker.sv @@
// Scoreboard for the timer pool service: slot pool prediction and word-by-word comparison
module timer_pool_service_checker
    import tps_pkg::*;
#(
    parameter int POOL_SIZE = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_cmd    i_cmd,
    input  logic    i_strobe,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_expiries,
    output int      o_full_answers,
    output int      o_miss_answers
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        slot_live   [POOL_SIZE];
    logic [7:0]  slot_task   [POOL_SIZE];
    logic [7:0]  slot_sig    [POOL_SIZE];
    longint      slot_count  [POOL_SIZE];
    logic [30:0] slot_reload [POOL_SIZE];
    logic [31:0] tick_total;
    logic [4:0]  live_count;
    t_result     awaited_words[$];
    int          mismatches = 0;
    int          expiries = 0;
    int          fulls = 0;
    int          misses = 0;

    function automatic int find_live(input logic [7:0] task_id, input logic [7:0] sig);
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (slot_live[i] && slot_task[i] == task_id && slot_sig[i] == sig) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void predict_answer(input t_cmd c);
        t_result    words[$];
        t_result    word;
        logic [1:0] status;
        longint     spent;
        int         hit;
        status = ST_OK;
        case (c.operation)
            OP_SET: begin
                hit = find_live(c.task_id, c.signal);
                if (hit < 0) begin
                    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
                        if (!slot_live[i]) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        status = ST_FULL;
                        fulls++;
                    end else begin
                        slot_task[hit]   = c.task_id;
                        slot_sig[hit]    = c.signal;
                        slot_reload[hit] = c.periodic ? c.duration : '0;
                        slot_live[hit]   = 1'b1;
                        live_count++;
                    end
                end
                if (status == ST_OK) begin
                    slot_count[hit] = longint'({33'd0, c.duration});
                end
            end
            OP_REMOVE: begin
                hit = find_live(c.task_id, c.signal);
                if (hit < 0) begin
                    status = ST_NOT_FOUND;
                    misses++;
                end else begin
                    slot_live[hit] = 1'b0;
                    if (live_count != 0) begin
                        live_count--;
                    end
                end
            end
            OP_TICK: begin
                tick_total = tick_total + {16'd0, c.tick_amount};
            end
            OP_SERVICE: begin
                spent = longint'({32'd0, tick_total});
                tick_total = '0;
                for (int i = 0; i < POOL_SIZE; i++) begin
                    if (slot_live[i]) begin
                        slot_count[i] = slot_count[i] - spent;
                        if (slot_count[i] <= 0) begin
                            word = '0;
                            word.kind           = KIND_EXPIRY;
                            word.status         = ST_OK;
                            word.expired_task   = slot_task[i];
                            word.expired_signal = slot_sig[i];
                            words.push_back(word);
                            expiries++;
                            if (slot_reload[i] == '0) begin
                                slot_live[i] = 1'b0;
                                if (live_count != 0) begin
                                    live_count--;
                                end
                            end else begin
                                slot_count[i] = longint'({33'd0, slot_reload[i]});
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        word = '0;
        word.kind   = KIND_ACK;
        word.status = status;
        word.last   = 1'b1;
        words.push_back(word);
        foreach (words[k]) begin
            word = words[k];
            word.slots_used = live_count;
            awaited_words.push_back(word);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (slot_live[i]) begin
                slot_live[i]   = 1'b0;
                slot_task[i]   = '0;
                slot_sig[i]    = '0;
                slot_count[i]  = 0;
                slot_reload[i] = '0;
            end
            tick_total = '0;
            live_count = '0;
            awaited_words.delete();
        end else begin
            if (i_strobe !== 1'b0) begin
                if (awaited_words.size() == 0) begin
                    $error("result word with none awaited: %0h", i_result);
                    mismatches++;
                end else begin
                    want = awaited_words.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(i_result.kind));
                    compare_field("status", 32'(want.status), 32'(i_result.status));
                    compare_field("expired_task", 32'(want.expired_task),
                                  32'(i_result.expired_task));
                    compare_field("expired_signal", 32'(want.expired_signal),
                                  32'(i_result.expired_signal));
                    compare_field("slots_used", 32'(want.slots_used),
                                  32'(i_result.slots_used));
                    compare_field("last", 32'(want.last), 32'(i_result.last));
                end
            end
            if (i_start && !i_busy) begin
                predict_answer(i_cmd);
            end
        end
        o_fail_count   <= mismatches;
        o_pending      <= awaited_words.size();
        o_expiries     <= expiries;
        o_full_answers <= fulls;
        o_miss_answers <= misses;
    end

endmodule

@@ sim/timer_pool_service_tb.sv @@
// Testbench top for the timer pool service: command stimulus in phases and the verdict
module timer_pool_service_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tps_pkg::*;

    localparam int POOL_SIZE        = 16;
    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 9;
    localparam int RANDOM_PER_PHASE = 135;
    localparam int TICK_RUN_ADDS    = 8;
    localparam int TAIL_CYCLES      = 2 * POOL_SIZE + 8;
    localparam int LIMIT_CYCLES     = 2_000_000;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_cmd    cmd = '0;
    logic    strobe;
    t_result result;

    int      fail_count;
    int      pending;
    int      expiries;
    int      fulls;
    int      misses;
    int      idle_pct = 0;
    int      issued = 0;
    int      cycle_count = 0;

    timer_pool_service #(
        .POOL_SIZE(POOL_SIZE)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd),
        .o_strobe(strobe),
        .o_result(result)
    );

    timer_pool_service_checker #(
        .POOL_SIZE(POOL_SIZE)
    ) scoreboard (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_cmd         (cmd),
        .i_strobe      (strobe),
        .i_result      (result),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_expiries    (expiries),
        .o_full_answers(fulls),
        .o_miss_answers(misses)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(input logic [1:0] op, input logic [7:0] task_id,
                                      input logic [7:0] sig, input logic [30:0] dur,
                                      input logic per, input logic [15:0] ticks);
        t_cmd c;
        c.operation   = op;
        c.task_id     = task_id;
        c.signal      = sig;
        c.duration    = dur;
        c.periodic    = per;
        c.tick_amount = ticks;
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   roll;
        c.task_id     = 8'($urandom);
        c.signal      = 8'($urandom);
        c.periodic    = 1'($urandom);
        c.tick_amount = 16'($urandom);
        roll = $urandom_range(99);
        if (roll < 40) begin
            c.operation = OP_SET;
        end else if (roll < 60) begin
            c.operation = OP_REMOVE;
        end else if (roll < 85) begin
            c.operation = OP_TICK;
        end else begin
            c.operation = OP_SERVICE;
        end
        if ($urandom_range(99) < 80) begin
            c.task_id = 8'($urandom_range(4));
            c.signal  = 8'($urandom_range(4));
        end
        roll = $urandom_range(99);
        if (roll < 60) begin
            c.duration = 31'($urandom_range(1500));
        end else if (roll < 85) begin
            c.duration = 31'($urandom_range(200000));
        end else begin
            c.duration = 31'($urandom);
        end
        if ($urandom_range(99) < 70) begin
            c.tick_amount = 16'($urandom_range(300));
        end
        return c;
    endfunction

    task automatic issue(input t_cmd c);
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        issued++;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input int pct);
        idle_pct = pct;
        repeat (RANDOM_PER_PHASE) issue(random_cmd());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        issue(make_cmd(OP_REMOVE, 8'h12, 8'h34, 31'd0, 1'b0, 16'd0));
        issue(make_cmd(OP_SERVICE, 8'h00, 8'h00, 31'd0, 1'b0, 16'd0));
        issue(make_cmd(OP_SET, 8'h00, 8'h00, 31'd0, 1'b0, 16'd0));
        issue(make_cmd(OP_SET, 8'hFF, 8'hFF, 31'h7FFF_FFFF, 1'b1, 16'hFFFF));
        issue(make_cmd(OP_SET, 8'h01, 8'h02, 31'd0, 1'b1, 16'd0));
        for (int i = 3; i < POOL_SIZE; i++) begin
            issue(make_cmd(OP_SET, 8'(i * 17), 8'(255 - 3 * i), 31'(i * i * 300), i[0],
                           16'(i)));
        end
        issue(make_cmd(OP_SET, 8'hA5, 8'h5A, 31'd50, 1'b0, 16'd0));
        issue(make_cmd(OP_SET, 8'hFF, 8'hFF, 31'd10, 1'b0, 16'd0));
        issue(make_cmd(OP_TICK, 8'h00, 8'h00, 31'd0, 1'b0, 16'hFFFF));
        issue(make_cmd(OP_SERVICE, 8'h00, 8'h00, 31'd0, 1'b0, 16'd0));
        issue(make_cmd(OP_REMOVE, 8'hFF, 8'hFF, 31'd0, 1'b0, 16'd0));
        issue(make_cmd(OP_REMOVE, 8'hFF, 8'hFF, 31'd0, 1'b0, 16'd0));
        issue(make_cmd(OP_TICK, 8'h00, 8'h00, 31'd0, 1'b0, 16'd0));

        issue(make_cmd(OP_SET, 8'h80, 8'h01, 31'h7FFF_FFFF, 1'b1, 16'd0));
        repeat (TICK_RUN_ADDS) issue(make_cmd(OP_TICK, 8'h00, 8'h00, 31'd0, 1'b0, 16'hFFFF));
        issue(make_cmd(OP_SERVICE, 8'h00, 8'h00, 31'd0, 1'b0, 16'd0));
        issue(make_cmd(OP_SET, 8'h80, 8'h02, 31'd255, 1'b0, 16'd0));
        issue(make_cmd(OP_SET, 8'h80, 8'h03, 31'd256, 1'b0, 16'd0));
        repeat (TICK_RUN_ADDS) issue(make_cmd(OP_TICK, 8'h00, 8'h00, 31'd0, 1'b0, 16'hFFFF));
        issue(make_cmd(OP_TICK, 8'h00, 8'h00, 31'd0, 1'b0, 16'h0100));
        issue(make_cmd(OP_SERVICE, 8'h00, 8'h00, 31'd0, 1'b0, 16'd0));

        run_phase(0);
        run_phase(75);
        run_phase(31);

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d commands, two of them runs of %0d maximum tick adds",
                 issued, TICK_RUN_ADDS);
        $display("Expiry notices: %0d, pool-full answers: %0d, not-found answers: %0d",
                 expiries, fulls, misses);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/tps_pkg.sv
sv/tps_ram.sv
sv/tps_core.sv
sv/timer_pool_service.sv
sv/tps_checker.sv
sim/timer_pool_service_checker.sv
sim/timer_pool_service_tb.sv
